// ===== rtl/core/lps_pkg.sv =====
package lps_pkg;

    // Line buffer depth and derived widths
    localparam int MAX_ROW_LENGTH = 1024;
    localparam int ADDR_W         = $clog2(MAX_ROW_LENGTH);
    localparam int LEN_W          = ADDR_W + 1;

    // Field and register widths
    localparam int DATA_W     = 32;
    localparam int ROW_W      = 16;
    localparam int COL_W      = 10;
    localparam int RLEN_W     = 11;
    localparam int SCALE_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE      = CFG_IDX_W'(2);

    // Register reset values (scale 1.0 in Q16.16)
    localparam logic [ROW_W-1:0]   ROW_COUNT_RST  = ROW_W'(32);
    localparam logic [RLEN_W-1:0]  ROW_LENGTH_RST = RLEN_W'(32);
    localparam logic [SCALE_W-1:0] SCALE_RST      = SCALE_W'(65536);

    // Smallest grid dimension that has an interior point
    localparam int MIN_DIM = 3;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Result buffer at the output
    localparam int OUT_DEPTH = 16;
    localparam int OPTR_W    = $clog2(OUT_DEPTH);
    localparam int OCNT_W    = OPTR_W + 1;
    localparam int OCC_W     = OCNT_W + 1;

    // Arithmetic pipeline: stages after the line buffer read
    localparam int EMIT_STAGES = 6;
    localparam int FLIGHT_W    = $clog2(EMIT_STAGES + 2);
    localparam int SUM_W       = DATA_W + 3;
    localparam int PROD_W      = SUM_W + FRAC_W;
    localparam int RND_W       = PROD_W - FRAC_W;
    localparam int RES_W       = PROD_W + 1;
    localparam int ROUND_HALF  = 1 << (FRAC_W - 1);

    typedef struct packed {
        logic [ROW_W-1:0]   row_count;
        logic [RLEN_W-1:0]  row_length;
        logic [SCALE_W-1:0] scale;
    } lps_cfg_t;

    // One classified sample travelling from front to back
    typedef struct packed {
        logic [DATA_W-1:0] sample;
        logic [ADDR_W-1:0] col;
        logic [ROW_W-1:0]  row;
        logic              emit;
        logic              last;
    } lps_item_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } lps_meta_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              last;
    } lps_result_t;

endpackage

// ===== rtl/core/lps_if.sv =====
interface lps_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [lps_pkg::DATA_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface lps_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [lps_pkg::DATA_W-1:0] value;
    logic        [lps_pkg::ROW_W-1:0]  row;
    logic        [lps_pkg::COL_W-1:0]  col;
    logic                              last;

    modport source (output valid, output value, output row, output col, output last,
                    input ready);
    modport sink (input valid, input value, input row, input col, input last,
                  output ready);
endinterface

// ===== rtl/core/lps_ram.sv =====
module lps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Register both read ports
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem_reg[rd_addr_a];
            rd_data_b <= mem_reg[rd_addr_b];
        end
    end

endmodule

// ===== rtl/core/lps_front.sv =====
module lps_front (
    input  logic                clk,
    input  logic                rst_n,
    input  lps_pkg::lps_cfg_t   cfg,
    lps_in_if.sink              in_chan,
    output logic                push_valid,
    input  logic                push_ready,
    output lps_pkg::lps_item_t  push_item
);

    logic [lps_pkg::ADDR_W-1:0] col_pos_reg;
    logic [lps_pkg::ADDR_W-1:0] col_pos_next;
    logic [lps_pkg::ROW_W-1:0]  row_pos_reg;
    logic [lps_pkg::ROW_W-1:0]  row_pos_next;

    logic                       accept;
    logic [lps_pkg::LEN_W-1:0]  len_eff;
    logic [lps_pkg::ROW_W-1:0]  rows_eff;
    logic                       col_wrap;
    logic [lps_pkg::ADDR_W-1:0] col_cur;
    logic [lps_pkg::ROW_W:0]    row_inc;
    logic [lps_pkg::ROW_W-1:0]  row_cur;
    logic [lps_pkg::LEN_W-1:0]  col_inc;
    logic [lps_pkg::ROW_W:0]    row_adv;

    // Pass the handshake straight to the queue
    assign push_valid    = in_chan.valid;
    assign in_chan.ready = push_ready;
    assign accept        = in_chan.valid && push_ready;

    // Clamp the grid dimensions
    always_comb
    begin
        len_eff = lps_pkg::LEN_W'(cfg.row_length);
        if (len_eff < lps_pkg::LEN_W'(lps_pkg::MIN_DIM))
        begin
            len_eff = lps_pkg::LEN_W'(lps_pkg::MIN_DIM);
        end
        else if (len_eff > lps_pkg::LEN_W'(lps_pkg::MAX_ROW_LENGTH))
        begin
            len_eff = lps_pkg::LEN_W'(lps_pkg::MAX_ROW_LENGTH);
        end
        rows_eff = (cfg.row_count < lps_pkg::ROW_W'(lps_pkg::MIN_DIM))
                 ? lps_pkg::ROW_W'(lps_pkg::MIN_DIM) : cfg.row_count;
    end

    // Place the sample, classify it and advance the raster position
    always_comb
    begin
        col_wrap = {1'b0, col_pos_reg} >= len_eff;
        col_cur  = col_wrap ? '0 : col_pos_reg;
        row_inc  = {1'b0, row_pos_reg} + (col_wrap ? (lps_pkg::ROW_W+1)'(1) : '0);
        row_cur  = (row_inc >= {1'b0, rows_eff}) ? '0 : row_inc[lps_pkg::ROW_W-1:0];
        col_inc  = {1'b0, col_cur} + lps_pkg::LEN_W'(1);
        row_adv  = {1'b0, row_cur} + (lps_pkg::ROW_W+1)'(1);

        push_item.sample = in_chan.sample;
        push_item.col    = col_cur;
        push_item.row    = row_cur - lps_pkg::ROW_W'(1);
        push_item.emit   = (row_cur >= lps_pkg::ROW_W'(2)) && (col_cur != '0)
                         && (col_inc < len_eff);
        push_item.last   = (row_cur == rows_eff - lps_pkg::ROW_W'(1))
                         && ({1'b0, col_cur} == len_eff - lps_pkg::LEN_W'(2));

        if (col_inc >= len_eff)
        begin
            col_pos_next = '0;
            row_pos_next = (row_adv >= {1'b0, rows_eff}) ? '0
                         : row_adv[lps_pkg::ROW_W-1:0];
        end
        else
        begin
            col_pos_next = col_inc[lps_pkg::ADDR_W-1:0];
            row_pos_next = row_cur;
        end
    end

    // Hold the position between requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end
        else if (accept)
        begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
        end
    end

    a_last_is_interior: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && push_item.last) |-> push_item.emit)
        else $error("last flag set on a border point");

endmodule

// ===== rtl/core/lps_queue.sv =====
module lps_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  lps_pkg::lps_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output lps_pkg::lps_item_t pop_item
);

    lps_pkg::lps_item_t         slot_reg [lps_pkg::QUEUE_DEPTH];
    logic [lps_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [lps_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [lps_pkg::QCNT_W-1:0] count_reg;
    logic [lps_pkg::QCNT_W-1:0] count_next;
    logic                       push;
    logic                       pop;

    assign push_ready = count_reg != lps_pkg::QCNT_W'(lps_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + lps_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - lps_pkg::QCNT_W'(1);
        end
    end

    // Store the incoming request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + lps_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + lps_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/lps_back.sv =====
module lps_back (
    input  logic               clk,
    input  logic               rst_n,
    input  lps_pkg::lps_cfg_t  cfg,
    input  logic               q_valid,
    output logic               q_ready,
    input  lps_pkg::lps_item_t q_item,
    lps_out_if.source          out_chan
);

    localparam int LINE_W = 2 * lps_pkg::DATA_W;

    // Line buffer access
    logic                           pop;
    logic [lps_pkg::ADDR_W-1:0]     rd_addr_a;
    logic [lps_pkg::ADDR_W-1:0]     rd_addr_b;
    logic [LINE_W-1:0]              rd_data_a;
    logic [LINE_W-1:0]              rd_data_b;
    logic [lps_pkg::DATA_W-1:0]     north;
    logic [lps_pkg::DATA_W-1:0]     center;
    logic [lps_pkg::DATA_W-1:0]     east;

    // Pipeline registers
    logic                           s1_valid_reg;
    lps_pkg::lps_item_t             s1_item_reg;
    logic [lps_pkg::DATA_W-1:0]     west_reg;
    logic [lps_pkg::EMIT_STAGES-1:0] vld_reg;
    lps_pkg::lps_meta_t             meta_reg [lps_pkg::EMIT_STAGES];
    logic [3:0]                     neg_reg;
    logic [lps_pkg::DATA_W:0]       ns_reg;
    logic [lps_pkg::DATA_W:0]       we_reg;
    logic [lps_pkg::DATA_W-1:0]     ctr_reg;
    logic [lps_pkg::SUM_W-1:0]      sum_reg;
    logic [lps_pkg::SUM_W-1:0]      mag_reg;
    logic [lps_pkg::PROD_W-1:0]     hi_reg;
    logic [lps_pkg::PROD_W-1:0]     lo_reg;
    logic [lps_pkg::PROD_W-1:0]     hi2_reg;
    logic [lps_pkg::RND_W-1:0]      rnd_reg;
    logic [lps_pkg::RES_W-1:0]      res_reg;
    logic [lps_pkg::PROD_W-1:0]     lo_sum;

    // Result buffer
    lps_pkg::lps_result_t           out_mem_reg [lps_pkg::OUT_DEPTH];
    logic [lps_pkg::OPTR_W-1:0]     out_wr_reg;
    logic [lps_pkg::OPTR_W-1:0]     out_rd_reg;
    logic [lps_pkg::OCNT_W-1:0]     out_count_reg;
    logic [lps_pkg::OCNT_W-1:0]     out_count_next;
    logic                           out_push;
    logic                           out_pop;
    logic                           over;
    lps_pkg::lps_result_t           result;
    lps_pkg::lps_result_t           head;
    logic [lps_pkg::FLIGHT_W-1:0]   inflight;
    logic [lps_pkg::OCC_W-1:0]      occupancy;

    // Count results still in the arithmetic pipeline
    always_comb
    begin
        inflight = lps_pkg::FLIGHT_W'(s1_valid_reg && s1_item_reg.emit);
        for (int i = 0; i < lps_pkg::EMIT_STAGES; i++)
        begin
            inflight = inflight + lps_pkg::FLIGHT_W'(vld_reg[i]);
        end
        occupancy = lps_pkg::OCC_W'(out_count_reg) + lps_pkg::OCC_W'(inflight);
    end

    // Take a request only when the result buffer has room for it
    assign q_ready   = occupancy < lps_pkg::OCC_W'(lps_pkg::OUT_DEPTH);
    assign pop       = q_valid && q_ready;
    assign rd_addr_a = q_item.col;
    assign rd_addr_b = q_item.col + lps_pkg::ADDR_W'(1);

    // Each entry holds {row before previous, previous row} at one column
    lps_ram #(
        .WIDTH (LINE_W),
        .DEPTH (lps_pkg::MAX_ROW_LENGTH)
    ) u_line_ram (
        .clk       (clk),
        .wr_en     (s1_valid_reg),
        .wr_addr   (s1_item_reg.col),
        .wr_data   ({center, s1_item_reg.sample}),
        .rd_en     (pop),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign north  = rd_data_a[LINE_W-1:lps_pkg::DATA_W];
    assign center = rd_data_a[lps_pkg::DATA_W-1:0];
    assign east   = rd_data_b[lps_pkg::DATA_W-1:0];
    assign lo_sum = lo_reg + lps_pkg::PROD_W'(lps_pkg::ROUND_HALF);

    // Advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            vld_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= pop;
            vld_reg      <= {vld_reg[lps_pkg::EMIT_STAGES-2:0],
                             s1_valid_reg && s1_item_reg.emit};
        end
    end

    // Stencil sum, magnitude, scale, round
    always_ff @(posedge clk)
    begin
        s1_item_reg <= q_item;
        if (s1_valid_reg)
        begin
            west_reg <= center;
        end
        ns_reg  <= {north[lps_pkg::DATA_W-1], north}
                 + {s1_item_reg.sample[lps_pkg::DATA_W-1], s1_item_reg.sample};
        we_reg  <= {west_reg[lps_pkg::DATA_W-1], west_reg}
                 + {east[lps_pkg::DATA_W-1], east};
        ctr_reg <= center;
        meta_reg[0].row  <= s1_item_reg.row;
        meta_reg[0].col  <= lps_pkg::COL_W'(s1_item_reg.col);
        meta_reg[0].last <= s1_item_reg.last;
        for (int k = 1; k < lps_pkg::EMIT_STAGES; k++)
        begin
            meta_reg[k] <= meta_reg[k-1];
        end

        sum_reg <= {{2{ns_reg[lps_pkg::DATA_W]}}, ns_reg}
                 + {{2{we_reg[lps_pkg::DATA_W]}}, we_reg}
                 - {ctr_reg[lps_pkg::DATA_W-1], ctr_reg, 2'b00};

        neg_reg[0] <= sum_reg[lps_pkg::SUM_W-1];
        mag_reg    <= sum_reg[lps_pkg::SUM_W-1] ? (~sum_reg + lps_pkg::SUM_W'(1)) : sum_reg;

        neg_reg[1] <= neg_reg[0];
        hi_reg     <= lps_pkg::PROD_W'(mag_reg)
                    * lps_pkg::PROD_W'(cfg.scale[lps_pkg::SCALE_W-1:lps_pkg::FRAC_W]);
        lo_reg     <= lps_pkg::PROD_W'(mag_reg)
                    * lps_pkg::PROD_W'(cfg.scale[lps_pkg::FRAC_W-1:0]);

        neg_reg[2] <= neg_reg[1];
        hi2_reg    <= hi_reg;
        rnd_reg    <= lo_sum[lps_pkg::PROD_W-1:lps_pkg::FRAC_W];

        neg_reg[3] <= neg_reg[2];
        res_reg    <= lps_pkg::RES_W'(hi2_reg) + lps_pkg::RES_W'(rnd_reg);
    end

    // Saturate and restore the sign
    always_comb
    begin
        over        = |res_reg[lps_pkg::RES_W-1:lps_pkg::DATA_W-1];
        result.row  = meta_reg[lps_pkg::EMIT_STAGES-1].row;
        result.col  = meta_reg[lps_pkg::EMIT_STAGES-1].col;
        result.last = meta_reg[lps_pkg::EMIT_STAGES-1].last;
        if (neg_reg[3])
        begin
            result.value = over ? {1'b1, {(lps_pkg::DATA_W-1){1'b0}}}
                         : (~res_reg[lps_pkg::DATA_W-1:0] + lps_pkg::DATA_W'(1));
        end
        else
        begin
            result.value = over ? {1'b0, {(lps_pkg::DATA_W-1){1'b1}}}
                         : res_reg[lps_pkg::DATA_W-1:0];
        end
    end

    // Result buffer toward the sink
    assign out_push       = vld_reg[lps_pkg::EMIT_STAGES-1];
    assign out_pop        = out_chan.valid && out_chan.ready;
    assign head           = out_mem_reg[out_rd_reg];
    assign out_chan.valid = out_count_reg != '0;
    assign out_chan.value = head.value;
    assign out_chan.row   = head.row;
    assign out_chan.col   = head.col;
    assign out_chan.last  = head.last;

    always_comb
    begin
        out_count_next = out_count_reg;
        if (out_push && !out_pop)
        begin
            out_count_next = out_count_reg + lps_pkg::OCNT_W'(1);
        end
        else if (out_pop && !out_push)
        begin
            out_count_next = out_count_reg - lps_pkg::OCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            out_mem_reg[out_wr_reg] <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg    <= '0;
            out_rd_reg    <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            if (out_push)
            begin
                out_wr_reg <= out_wr_reg + lps_pkg::OPTR_W'(1);
            end
            if (out_pop)
            begin
                out_rd_reg <= out_rd_reg + lps_pkg::OPTR_W'(1);
            end
            out_count_reg <= out_count_next;
        end
    end

    a_no_line_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && s1_valid_reg) |->
            (rd_addr_a != s1_item_reg.col) && (rd_addr_b != s1_item_reg.col))
        else $error("line buffer read collides with pending write");

    a_buffer_credit: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= lps_pkg::OCC_W'(lps_pkg::OUT_DEPTH))
        else $error("results in flight exceed buffer space");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (out_count_reg != lps_pkg::OCNT_W'(lps_pkg::OUT_DEPTH)))
        else $error("result written into a full buffer");

endmodule

// ===== rtl/core/five_point_laplacian_stream.sv =====
// Samples pass the queue, line buffer read, arithmetic stages and result buffer.
// One sample per cycle unless stalled; each uses one line buffer read and write.
// Border samples produce no result; the arithmetic pipeline holds up to 7 requests,
// and a 16-entry result buffer absorbs them while the sink stalls.
// Reset clears the raster position, both queues and the registers to their defaults;
// the line buffer is not cleared; unwritten entries feed only border samples.
module five_point_laplacian_stream (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [lps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lps_pkg::CFG_DATA_W-1:0]   cfg_data,
    lps_in_if.sink                           in_chan,
    lps_out_if.source                        out_chan
);

    lps_pkg::lps_cfg_t  cfg_reg;
    logic               push_valid;
    logic               push_ready;
    lps_pkg::lps_item_t push_item;
    logic               q_valid;
    logic               q_ready;
    lps_pkg::lps_item_t q_item;

    // Decode register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_count  <= lps_pkg::ROW_COUNT_RST;
            cfg_reg.row_length <= lps_pkg::ROW_LENGTH_RST;
            cfg_reg.scale      <= lps_pkg::SCALE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lps_pkg::REG_ROW_COUNT:
                begin
                    cfg_reg.row_count <= cfg_data[lps_pkg::ROW_W-1:0];
                end
                lps_pkg::REG_ROW_LENGTH:
                begin
                    cfg_reg.row_length <= cfg_data[lps_pkg::RLEN_W-1:0];
                end
                lps_pkg::REG_SCALE:
                begin
                    cfg_reg.scale <= cfg_data[lps_pkg::SCALE_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    lps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_chan    (in_chan),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    lps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    lps_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .out_chan (out_chan)
    );

endmodule
